[src/gbglyph_pkg.sv]
`timescale 1ns / 1ps
// gbglyph_pkg: types, codes and font segment constants for the gb2312 glyph block
// no dependencies

package gbglyph_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_GLYPH        = 3'd0,
        ST_GLYPH_FULL   = 3'd1,
        ST_NEWLINE      = 3'd2,
        ST_NEWLINE_FULL = 3'd3,
        ST_END          = 3'd4,
        ST_BAD_CODE     = 3'd5
    } t_status;

    // configuration register indexes
    localparam logic [2:0] CFG_X_ORIGIN     = 3'd0;
    localparam logic [2:0] CFG_Y_ORIGIN     = 3'd1;
    localparam logic [2:0] CFG_VIEW_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_VIEW_HEIGHT  = 3'd3;
    localparam logic [2:0] CFG_ROW_GAP      = 3'd4;
    localparam logic [2:0] CFG_CHAR_ADVANCE = 3'd5;

    typedef struct packed {
        logic [7:0] x_origin;
        logic [6:0] y_origin;
        logic [7:0] view_width;
        logic [6:0] view_height;
        logic [6:0] row_gap;
        logic [7:0] char_advance;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        x_origin:     8'd0,
        y_origin:     7'd0,
        view_width:   8'd131,
        view_height:  7'd64,
        row_gap:      7'd1,
        char_advance: 8'd12
    };

    // special text bytes
    localparam logic [7:0] BYTE_END = 8'h00;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] LEAD_MIN = 8'hA0;

    // linear code offsets: two-byte form and full-width row 3 form
    localparam logic [15:0] ROW_CELLS    = 16'd94;
    localparam logic [15:0] PAIR_BIAS    = 16'd15295; // 0xA0*94 + 94 + 0xA0 + 1
    localparam logic [15:0] LOW_BIAS     = 16'd155;   // 2*94 - 0x20 - 1

    // font rom segments, searched from the last entry down
    localparam int SEG_COUNT = 11;
    localparam logic [23:0] SEG_ROM [SEG_COUNT] = '{
        24'h07FD10, 24'h0BF640, 24'h0E2920, 24'h0E2BD0, 24'h0E2C90, 24'h0E2D50,
        24'h0E2E60, 24'h0DEEA0, 24'h0BFE50, 24'h03ABF0, 24'h0F7020
    };
    // the last segment starts one span of glyph bytes past its listed code
    localparam logic [15:0] SEG_CODE_BASE [SEG_COUNT] = '{
        16'd0, 16'd110, 16'd376, 16'd470, 16'd502, 16'd564,
        16'd658, 16'd612, 16'd694, 16'd1410, 16'd1410
    };
    localparam int SEG_LAST_SPAN = 'h5400;

endpackage

[src/gbglyph_if.sv]
`timescale 1ns / 1ps
// gbglyph interfaces: text input, glyph result and configuration write channels
// depends on nothing

interface gbglyph_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] text_byte;

    modport source (output valid, output func, output text_byte, input ready);
    modport sink   (input valid, input func, input text_byte, output ready);
endinterface

interface gbglyph_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [23:0] glyph_address;
    logic [7:0]  glyph_x;
    logic [6:0]  glyph_y;

    modport source (output valid, output status, output glyph_address,
                    output glyph_x, output glyph_y, input ready);
    modport sink   (input valid, input status, input glyph_address,
                    input glyph_x, input glyph_y, output ready);
endinterface

interface gbglyph_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/gbglyph_cfg_regs.sv]
`timescale 1ns / 1ps
// gbglyph_cfg_regs: layout configuration registers behind the write channel
// depends on gbglyph_pkg and gbglyph_cfg_if

module gbglyph_cfg_regs
    import gbglyph_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    gbglyph_cfg_if.sink   i_cfg,
    output t_cfg          o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_X_ORIGIN:     r_cfg.x_origin     <= i_cfg.data;
                CFG_Y_ORIGIN:     r_cfg.y_origin     <= i_cfg.data[6:0];
                CFG_VIEW_WIDTH:   r_cfg.view_width   <= i_cfg.data;
                CFG_VIEW_HEIGHT:  r_cfg.view_height  <= i_cfg.data[6:0];
                CFG_ROW_GAP:      r_cfg.row_gap      <= i_cfg.data[6:0];
                CFG_CHAR_ADVANCE: r_cfg.char_advance <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

[src/gbglyph_addr.sv]
`timescale 1ns / 1ps
// gbglyph_addr: code point from text bytes and font rom address from the segment table
// depends on gbglyph_pkg

module gbglyph_addr
    import gbglyph_pkg::*;
#(
    parameter int GLYPH_BYTES = 24
) (
    input  logic        i_lead_pending,
    input  logic [7:0]  i_lead_byte,
    input  logic [7:0]  i_text_byte,
    output logic        o_bad_code,
    output logic [23:0] o_glyph_address
);

    localparam logic [15:0] LAST_EXTRA = 16'(SEG_LAST_SPAN / GLYPH_BYTES);
    localparam logic [23:0] BYTES_W    = 24'(GLYPH_BYTES);

    logic [15:0] w_cp;
    logic [23:0] w_cp_scaled;
    logic [23:0] w_base;

    // two's complement code point, negative for a pair that falls before row 1 cell 1
    always_comb begin
        if (i_lead_pending) begin
            w_cp = {8'd0, i_lead_byte} * ROW_CELLS + {8'd0, i_text_byte} - PAIR_BIAS;
        end else begin
            w_cp = {8'd0, i_text_byte} + LOW_BIAS;
        end
    end

    assign w_cp_scaled = {9'd0, w_cp[14:0]} * BYTES_W;

    // segment base minus its start code, folded to a constant per entry
    always_comb begin
        logic [15:0] code;
        w_base = SEG_ROM[0];
        for (int i = 0; i < SEG_COUNT; i++) begin
            code = SEG_CODE_BASE[i] + ((i == SEG_COUNT - 1) ? LAST_EXTRA : 16'd0);
            if ({1'b0, w_cp[14:0]} >= code) begin
                w_base = SEG_ROM[i] - 24'(code) * BYTES_W;
            end
        end
    end

    assign o_bad_code      = w_cp[15];
    assign o_glyph_address = w_base + w_cp_scaled;

endmodule

[src/gbglyph_core.sv]
`timescale 1ns / 1ps
// gbglyph_core: input register, text cursor state and result register
// depends on gbglyph_pkg, gbglyph_if and gbglyph_addr

module gbglyph_core
    import gbglyph_pkg::*;
#(
    parameter int GLYPH_BYTES = 24,
    parameter int GLYPH_ROWS  = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    gbglyph_in_if.sink      i_text,
    gbglyph_out_if.source   o_glyph
);

    localparam logic [9:0] ROWS_W = 10'(GLYPH_ROWS);

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_TEXT  = 3'b010,
        PH_FULL  = 3'b100
    } t_phase;

    // input register
    logic        r_s1_valid;
    logic        r_s1_func;
    logic [7:0]  r_s1_byte;

    // cursor state
    logic [7:0]  r_cursor_x, n_cursor_x;
    logic [6:0]  r_cursor_y, n_cursor_y;
    logic [7:0]  r_lead_byte, n_lead_byte;
    logic        r_lead_pending, n_lead_pending;
    t_phase      r_phase, n_phase;

    // result register
    logic        r_out_valid;
    t_status     r_out_status;
    logic [23:0] r_out_address;
    logic [7:0]  r_out_x;
    logic [6:0]  r_out_y;

    logic        w_out_free;
    logic        w_step;
    logic        w_in_fire;
    logic        w_has_result;
    t_status     w_status;
    logic [23:0] w_address;
    logic [7:0]  w_x;
    logic [6:0]  w_y;

    logic        w_page_reset;
    logic [7:0]  w_eff_x;
    logic [6:0]  w_eff_y;
    logic        w_eff_lead_pending;
    logic [7:0]  w_eff_lead;
    t_phase      w_eff_phase;
    logic        w_is_newline;
    logic [7:0]  w_adv_from;
    logic [9:0]  w_x_sum;
    logic        w_x_fits;
    logic [9:0]  w_y_next;
    logic        w_y_fits;
    logic        w_bad_code;
    logic [23:0] w_rom_address;

    assign w_out_free   = !r_out_valid || o_glyph.ready;
    assign w_step       = r_s1_valid && w_out_free;
    assign i_text.ready = !r_s1_valid || w_out_free;
    assign w_in_fire    = i_text.valid && i_text.ready;

    // a byte after a full page starts a fresh page first
    assign w_page_reset       = (r_phase == PH_FULL);
    assign w_eff_x            = w_page_reset ? i_cfg.x_origin : r_cursor_x;
    assign w_eff_y            = w_page_reset ? i_cfg.y_origin : r_cursor_y;
    assign w_eff_lead_pending = w_page_reset ? 1'b0 : r_lead_pending;
    assign w_eff_lead         = w_page_reset ? 8'd0 : r_lead_byte;
    assign w_eff_phase        = w_page_reset ? PH_START : r_phase;

    // a newline advances as a glyph placed at the right edge
    assign w_is_newline = !w_eff_lead_pending && (r_s1_byte == BYTE_LF);
    assign w_adv_from   = w_is_newline ? i_cfg.view_width : w_eff_x;
    assign w_x_sum      = {2'd0, w_adv_from} + {2'd0, i_cfg.char_advance};
    assign w_x_fits     = (w_x_sum + {2'd0, i_cfg.char_advance}) <= {2'd0, i_cfg.view_width};
    assign w_y_next     = {3'd0, w_eff_y} + ROWS_W + {3'd0, i_cfg.row_gap};
    assign w_y_fits     = (w_y_next + ROWS_W) <= {3'd0, i_cfg.view_height};

    gbglyph_addr #(
        .GLYPH_BYTES (GLYPH_BYTES)
    ) u_addr (
        .i_lead_pending  (w_eff_lead_pending),
        .i_lead_byte     (w_eff_lead),
        .i_text_byte     (r_s1_byte),
        .o_bad_code      (w_bad_code),
        .o_glyph_address (w_rom_address)
    );

    always_comb begin
        logic do_advance;
        logic full;
        n_cursor_x     = r_cursor_x;
        n_cursor_y     = r_cursor_y;
        n_lead_byte    = r_lead_byte;
        n_lead_pending = r_lead_pending;
        n_phase        = r_phase;
        w_has_result   = 1'b0;
        w_status       = ST_END;
        w_address      = 24'd0;
        w_x            = 8'd0;
        w_y            = 7'd0;
        do_advance     = 1'b0;
        full           = 1'b0;

        if (!w_x_fits && !w_y_fits) begin
            full = 1'b1;
        end

        if (w_step) begin
            if (r_s1_func) begin
                n_cursor_x     = i_cfg.x_origin;
                n_cursor_y     = i_cfg.y_origin;
                n_lead_byte    = 8'd0;
                n_lead_pending = 1'b0;
                n_phase        = PH_START;
            end else begin
                n_cursor_x     = w_eff_x;
                n_cursor_y     = w_eff_y;
                n_lead_byte    = w_eff_lead;
                n_lead_pending = w_eff_lead_pending;
                n_phase        = w_eff_phase;
                if (w_eff_lead_pending || r_s1_byte == BYTE_END) begin
                    n_lead_byte    = 8'd0;
                    n_lead_pending = 1'b0;
                    w_has_result   = 1'b1;
                    if (r_s1_byte == BYTE_END) begin
                        w_status = ST_END;
                    end else if (w_bad_code) begin
                        w_status = ST_BAD_CODE;
                    end else begin
                        do_advance = 1'b1;
                        w_status   = full ? ST_GLYPH_FULL : ST_GLYPH;
                        w_address  = w_rom_address;
                        w_x        = w_eff_x;
                        w_y        = w_eff_y;
                    end
                end else if (w_is_newline) begin
                    if (w_eff_phase == PH_START) begin
                        n_phase = PH_TEXT;
                    end else begin
                        do_advance   = 1'b1;
                        w_has_result = 1'b1;
                        w_status     = full ? ST_NEWLINE_FULL : ST_NEWLINE;
                    end
                end else begin
                    n_phase = PH_TEXT;
                    if (r_s1_byte >= LEAD_MIN) begin
                        n_lead_byte    = r_s1_byte;
                        n_lead_pending = 1'b1;
                    end else begin
                        do_advance   = 1'b1;
                        w_has_result = 1'b1;
                        w_status     = full ? ST_GLYPH_FULL : ST_GLYPH;
                        w_address    = w_rom_address;
                        w_x          = w_eff_x;
                        w_y          = w_eff_y;
                    end
                end

                if (do_advance) begin
                    if (w_x_fits) begin
                        n_cursor_x = w_x_sum[7:0];
                    end else if (w_y_fits) begin
                        n_cursor_x = i_cfg.x_origin;
                        n_cursor_y = w_y_next[6:0];
                    end else begin
                        n_phase = PH_FULL;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_cursor_x     <= CFG_RESET.x_origin;
            r_cursor_y     <= CFG_RESET.y_origin;
            r_lead_byte    <= 8'd0;
            r_lead_pending <= 1'b0;
            r_phase        <= PH_START;
        end else begin
            r_s1_valid     <= w_in_fire || (r_s1_valid && !w_out_free);
            r_cursor_x     <= n_cursor_x;
            r_cursor_y     <= n_cursor_y;
            r_lead_byte    <= n_lead_byte;
            r_lead_pending <= n_lead_pending;
            r_phase        <= n_phase;
            if (w_out_free) begin
                r_out_valid <= w_step && w_has_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_func <= i_text.func;
            r_s1_byte <= i_text.text_byte;
        end
        if (w_step && w_has_result) begin
            r_out_status  <= w_status;
            r_out_address <= w_address;
            r_out_x       <= w_x;
            r_out_y       <= w_y;
        end
    end

    assign o_glyph.valid         = r_out_valid;
    assign o_glyph.status        = r_out_status;
    assign o_glyph.glyph_address = r_out_address;
    assign o_glyph.glyph_x       = r_out_x;
    assign o_glyph.glyph_y       = r_out_y;

`ifndef SYNTHESIS
    a_lead_is_high_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lead_pending |-> (r_lead_byte >= LEAD_MIN))
        else $error("held lead byte below the lead range");

    a_full_sets_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_has_result &&
         (w_status == ST_GLYPH_FULL || w_status == ST_NEWLINE_FULL))
        |=> (r_phase == PH_FULL))
        else $error("page full reported but page not marked full");

    a_nonglyph_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_GLYPH && r_out_status != ST_GLYPH_FULL)
        |-> (r_out_address == 24'd0 && r_out_x == 8'd0 && r_out_y == 7'd0))
        else $error("non-glyph result carries glyph fields");

    a_s1_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_out_free) |=> (r_s1_valid && $stable(r_s1_byte)))
        else $error("input register lost an item under stall");
`endif

endmodule

[src/gb2312_glyph_address_and_text_layout.sv]
`timescale 1ns / 1ps
// gb2312_glyph_address_and_text_layout: top level of the glyph address and text cursor block
// depends on gbglyph_pkg, gbglyph_if, gbglyph_cfg_regs and gbglyph_core
//
// Usage:
//   i_text   valid/ready stream of text items: func=1 starts a new page, func=0 carries
//            one raw gb2312 byte (0 ends the text, a byte of 0xA0 or above is a lead byte)
//   o_glyph  valid/ready stream of results: status, font rom byte address and the
//            top-left pixel of the glyph; zero or one result per text item
//   i_cfg    register write channel (index, data), always ready; write only while idle
// Path: an item is held in the input register, and its result then in the result register.
// Throughput: one item per cycle while o_glyph does not stall; the cursor update and the
//   segment compare sit between the input register and the result register as combinational logic.
// Reset: registers return to their defaults, the cursor to the margins, the page
//   to its start and both pipeline registers empty.
// Stall: while o_glyph is held, the result waits in its register and one more item
//   is taken into the input register; i_text.ready then drops until the result moves.

module gb2312_glyph_address_and_text_layout
    import gbglyph_pkg::*;
#(
    parameter int GLYPH_BYTES = 24,
    parameter int GLYPH_ROWS  = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gbglyph_in_if.sink      i_text,
    gbglyph_out_if.source   o_glyph,
    gbglyph_cfg_if.sink     i_cfg
);

    t_cfg w_cfg;

    gbglyph_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    gbglyph_core #(
        .GLYPH_BYTES (GLYPH_BYTES),
        .GLYPH_ROWS  (GLYPH_ROWS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_text  (i_text),
        .o_glyph (o_glyph)
    );

endmodule

[tb/sv/gb2312_glyph_address_and_text_layout_test.sv]
`timescale 1ns / 1ps
// testbench for gb2312_glyph_address_and_text_layout: directed and random text streams
// with an item-level predictor of glyph address, cursor and page state
// depends on gbglyph_pkg, gbglyph_if and the block itself

module gb2312_glyph_address_and_text_layout_test;
    import gbglyph_pkg::*;

    localparam int GLYPH_BYTES = 24;
    localparam int GLYPH_ROWS  = 12;
    localparam int ROW_SPAN    = 94;
    localparam int NUM_SEGS    = 11;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 34;

    typedef enum logic [1:0] {
        PAGE_START,
        PAGE_BODY,
        PAGE_FULL
    } t_page;

    typedef struct {
        t_status     status;
        logic [23:0] addr;
        logic [7:0]  x;
        logic [6:0]  y;
    } t_glyph;

    // font rom segments, searched from the last entry down
    localparam int FONT_BASE [NUM_SEGS] = '{
        'h7FD10, 'hBF640, 'hE2920, 'hE2BD0, 'hE2C90, 'hE2D50,
        'hE2E60, 'hDEEA0, 'hBFE50, 'h3ABF0, 'hF7020
    };
    localparam int FONT_FIRST_CODE [NUM_SEGS] = '{
        0, 110, 376, 470, 502, 564, 658, 612, 694, 1410, 1410 + 'h5400 / GLYPH_BYTES
    };

    logic clk;
    logic rst_n;

    gbglyph_in_if  text_if ();
    gbglyph_out_if glyph_if ();
    gbglyph_cfg_if cfg_if ();

    gb2312_glyph_address_and_text_layout #(
        .GLYPH_BYTES (GLYPH_BYTES),
        .GLYPH_ROWS  (GLYPH_ROWS)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_text  (text_if),
        .o_glyph (glyph_if),
        .i_cfg   (cfg_if)
    );

    // predicted layout state
    int          cfg_lm, cfg_tm, cfg_sw, cfg_sh, cfg_ls, cfg_adv;
    logic [7:0]  cur_x;
    logic [6:0]  cur_y;
    logic [7:0]  lead_byte;
    bit          lead_held;
    t_page       phase;

    t_glyph      pending_glyphs [$];
    int          err_count;
    int          items_sent;
    int          cycle_count;
    bit          calm;
    int          hold_requests;
    int          hold_served;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void start_page();
        cur_x     = 8'(cfg_lm);
        cur_y     = 7'(cfg_tm);
        lead_held = 1'b0;
        lead_byte = 8'h00;
        phase     = PAGE_START;
    endfunction

    // moves the cursor on from column x, returns 1 when the page is full
    function automatic bit cursor_step(int x);
        int y;
        y = int'(cur_y) + GLYPH_ROWS;
        if (x + cfg_adv <= cfg_sw - cfg_adv) begin
            cur_x = 8'(x + cfg_adv);
            return 1'b0;
        end
        if (y + cfg_ls + GLYPH_ROWS <= cfg_sh) begin
            cur_x = 8'(cfg_lm);
            cur_y = 7'(y + cfg_ls);
            return 1'b0;
        end
        phase = PAGE_FULL;
        return 1'b1;
    endfunction

    function automatic void expect_marker(t_status st);
        t_glyph g;
        g.status = st;
        g.addr   = '0;
        g.x      = '0;
        g.y      = '0;
        pending_glyphs.push_back(g);
    endfunction

    function automatic void expect_glyph(int code);
        t_glyph g;
        bit     found;
        if (code < 0) begin
            expect_marker(ST_BAD_CODE);
            return;
        end
        g.addr = '0;
        found  = 1'b0;
        for (int i = NUM_SEGS - 1; i >= 0; i--) begin
            if (!found && code >= FONT_FIRST_CODE[i]) begin
                g.addr = 24'(FONT_BASE[i] + (code - FONT_FIRST_CODE[i]) * GLYPH_BYTES);
                found  = 1'b1;
            end
        end
        g.x      = cur_x;
        g.y      = cur_y;
        g.status = cursor_step(int'(cur_x)) ? ST_GLYPH_FULL : ST_GLYPH;
        pending_glyphs.push_back(g);
    endfunction

    function automatic void predict_layout(logic f, logic [7:0] b);
        int row, cell_pos;
        if (f) begin
            start_page();
            return;
        end
        if (phase == PAGE_FULL)
            start_page();
        if (lead_held) begin
            row       = int'(lead_byte) - int'(LEAD_MIN);
            cell_pos  = int'(b) - int'(LEAD_MIN);
            lead_held = 1'b0;
            lead_byte = 8'h00;
            if (b == BYTE_END)
                expect_marker(ST_END);
            else
                expect_glyph((row - 1) * ROW_SPAN + (cell_pos - 1));
            return;
        end
        if (b == BYTE_END) begin
            expect_marker(ST_END);
            return;
        end
        if (b == BYTE_LF) begin
            if (phase == PAGE_START) begin
                phase = PAGE_BODY;
                return;
            end
            // a newline acts as a glyph sitting at the right edge
            expect_marker(cursor_step(cfg_sw) ? ST_NEWLINE_FULL : ST_NEWLINE);
            return;
        end
        phase = PAGE_BODY;
        if (b >= LEAD_MIN) begin
            lead_byte = b;
            lead_held = 1'b1;
            return;
        end
        // single byte maps to the full-width form in row 3
        expect_glyph(2 * ROW_SPAN + int'(b) - 'h20 - 1);
    endfunction

    // ---------------------------------------------------------------- result side

    task automatic report_mismatch(string what, t_glyph want);
        err_count++;
        if (err_count <= 10) begin
            $display("mismatch (%s) at %0t: expected st=%0d addr=%06h x=%0d y=%0d",
                     what, $realtime, want.status, want.addr, want.x, want.y);
            $display("    got st=%0d addr=%06h x=%0d y=%0d",
                     glyph_if.status, glyph_if.glyph_address, glyph_if.glyph_x,
                     glyph_if.glyph_y);
        end
    endtask

    initial begin
        t_glyph want;
        int     hold_left;
        hold_left      = 0;
        glyph_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && glyph_if.valid && glyph_if.ready) begin
                if (pending_glyphs.size() == 0) begin
                    want.status = ST_GLYPH;
                    want.addr   = '0;
                    want.x      = '0;
                    want.y      = '0;
                    report_mismatch("unexpected transfer", want);
                end else begin
                    want = pending_glyphs.pop_front();
                    if (glyph_if.status !== want.status ||
                        glyph_if.glyph_address !== want.addr ||
                        glyph_if.glyph_x !== want.x ||
                        glyph_if.glyph_y !== want.y)
                        report_mismatch("field", want);
                end
            end
            if (hold_left == 0 && hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                glyph_if.ready <= 1'b0;
            end else begin
                glyph_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_text(logic f, logic [7:0] b);
        int gap;
        text_if.valid     <= 1'b1;
        text_if.func      <= f;
        text_if.text_byte <= b;
        do @(posedge clk); while (!text_if.ready);
        predict_layout(f, b);
        items_sent++;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            gap = $urandom_range(2, 1);
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering text and wait out every expected result plus the pipe
    task automatic settle_idle();
        text_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_glyphs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            CFG_X_ORIGIN:     cfg_lm  = int'(val);
            CFG_Y_ORIGIN:     cfg_tm  = int'(val[6:0]);
            CFG_VIEW_WIDTH:   cfg_sw  = int'(val);
            CFG_VIEW_HEIGHT:  cfg_sh  = int'(val[6:0]);
            CFG_ROW_GAP:      cfg_ls  = int'(val[6:0]);
            CFG_CHAR_ADVANCE: cfg_adv = int'(val);
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_config(int lm, int tm, int sw, int sh, int ls, int adv);
        settle_idle();
        write_reg(CFG_X_ORIGIN, 8'(lm));
        write_reg(CFG_Y_ORIGIN, 8'(tm));
        write_reg(CFG_VIEW_WIDTH, 8'(sw));
        write_reg(CFG_VIEW_HEIGHT, 8'(sh));
        write_reg(CFG_ROW_GAP, 8'(ls));
        write_reg(CFG_CHAR_ADVANCE, 8'(adv));
    endtask

    task automatic send_pair(logic [7:0] lead, logic [7:0] trail);
        send_text(1'b0, lead);
        send_text(1'b0, trail);
    endtask

    // mostly well-formed text with random content, plus noise
    task automatic send_random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35) begin
            if ($urandom_range(9) < 8)
                send_pair(8'($urandom_range(255, 160)), 8'($urandom_range(254, 161)));
            else
                send_pair(8'($urandom_range(255, 160)), 8'($urandom_range(255, 0)));
        end else if (pick < 65) begin
            send_text(1'b0, 8'($urandom_range(8'h7E, 8'h20)));
        end else if (pick < 75) begin
            send_text(1'b0, BYTE_LF);
        end else if (pick < 78) begin
            send_text(1'b0, BYTE_END);
        end else if (pick < 82) begin
            send_text(1'b1, 8'($urandom_range(255, 0)));
        end else begin
            send_text(1'b0, 8'($urandom_range(255, 0)));
        end
    endtask

    task automatic send_random_run(int n);
        int target;
        target = items_sent + n;
        while (items_sent < target)
            send_random_item();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_defaults();
        send_text(1'b1, 8'h00);
        send_text(1'b0, BYTE_LF);      // leading newline is skipped
        send_text(1'b0, 8'h41);
        send_text(1'b0, BYTE_LF);
        send_text(1'b0, 8'h01);
        send_text(1'b0, 8'h9F);
        send_text(1'b0, 8'h7F);
        send_pair(8'hA0, 8'hA1);       // row 0: negative code
        send_pair(8'hA1, 8'hA0);       // row 1 cell 0: negative code
        send_pair(8'hA1, 8'hA1);
        send_pair(8'hFF, 8'hFF);
        send_pair(8'hB0, BYTE_LF);     // newline taken as cell
        send_pair(8'hA1, BYTE_END);    // end drops the lead byte
        send_text(1'b0, 8'hC0);
        send_text(1'b1, 8'hFF);        // new page drops the lead byte
        send_text(1'b0, BYTE_LF);
        send_text(1'b0, BYTE_END);
    endtask

    task automatic test_tiny_screen();
        apply_config(0, 0, 1, 1, 0, 1);
        send_text(1'b0, 8'h41);        // fills the page at once
        send_text(1'b0, 8'h42);        // starts a new page first
        send_text(1'b0, BYTE_LF);      // new page, then skipped
        send_text(1'b0, BYTE_LF);
        send_text(1'b0, BYTE_END);
        send_pair(8'hA1, 8'hA1);
    endtask

    task automatic test_max_config();
        apply_config(255, 127, 255, 127, 127, 255);
        send_text(1'b1, 8'h00);
        send_text(1'b0, 8'h41);
        send_pair(8'hF7, 8'hFE);
        send_text(1'b0, BYTE_LF);
    endtask

    task automatic test_random_phases();
        apply_config(0, 0, 131, 64, 1, 12);
        send_random_run(160);
        apply_config(0, 0, 255, 127, 0, 1);
        calm = 1'b1;
        send_random_run(160);
        calm = 1'b0;
        repeat (2) begin
            apply_config($urandom_range(60), $urandom_range(40), $urandom_range(255, 1),
                         $urandom_range(127, 1), $urandom_range(10), $urandom_range(30, 1));
            send_text(1'b1, 8'h00);
            send_random_run(140);
        end
        apply_config($urandom_range(255), $urandom_range(127), $urandom_range(60, 1),
                     $urandom_range(40, 1), $urandom_range(127), $urandom_range(255, 1));
        send_random_run(120);
    endtask

    task automatic test_backpressure();
        apply_config(4, 2, 200, 100, 3, 9);
        send_text(1'b1, 8'h00);
        calm = 1'b1;
        hold_requests++;
        // sender keeps offering while the receiver holds off
        repeat (30) send_text(1'b0, 8'($urandom_range(8'h7E, 8'h21)));
        calm = 1'b0;
        settle_idle();
        send_random_run(60);
    endtask

    initial begin
        rst_n             = 1'b0;
        text_if.valid     = 1'b0;
        text_if.func      = 1'b0;
        text_if.text_byte = 8'h00;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_X_ORIGIN;
        cfg_if.data       = 8'h00;
        err_count         = 0;
        items_sent        = 0;
        calm              = 1'b0;
        hold_requests     = 0;
        hold_served       = 0;
        cfg_lm  = int'(CFG_RESET.x_origin);
        cfg_tm  = int'(CFG_RESET.y_origin);
        cfg_sw  = int'(CFG_RESET.view_width);
        cfg_sh  = int'(CFG_RESET.view_height);
        cfg_ls  = int'(CFG_RESET.row_gap);
        cfg_adv = int'(CFG_RESET.char_advance);
        start_page();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_tiny_screen();
        test_max_config();
        test_random_phases();
        test_backpressure();

        settle_idle();
        repeat (10) @(posedge clk);
        if (err_count == 0 && pending_glyphs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
